[hdl/hfbt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfbt_pkg
// Shared types and constants of the host failure backoff table.
// ----------------------------------------------------------------------------
package hfbt_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 36;

  localparam logic [7:0]  BASE_RST  = 8'd60;
  localparam logic [4:0]  JIT_RST   = 5'd0;
  localparam logic [3:0]  WSH_RST   = 4'd6;
  localparam logic [15:0] HOLD_RST  = 16'd120;
  localparam logic [3:0]  MAXE_RST  = 4'd10;
  localparam logic [4:0]  AGE_RST   = 5'd10;

  typedef enum logic [2:0] {
    REG_BASE = 3'd0,
    REG_JIT  = 3'd1,
    REG_WSH  = 3'd2,
    REG_HOLD = 3'd3,
    REG_MAXE = 3'd4,
    REG_AGE  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_QUERY   = 2'd0,
    KIND_SUCCESS = 2'd1,
    KIND_FAILURE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_QUERY,
    OP_SUCCESS,
    OP_FAILURE,
    OP_NONE
  } op_t;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_CLEARED  = 3'd1,
    ACT_COUNTED  = 3'd2,
    ACT_HELD     = 3'd3,
    ACT_INSERTED = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ES_IDLE,
    ES_SCAN,
    ES_DECIDE,
    ES_OUT
  } eng_state_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] addr;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [3:0]  cnt;
    logic [31:0] tstamp;
  } entry_t;

  typedef struct packed {
    logic [7:0]  base_seconds;
    logic [4:0]  jitter;
    logic [3:0]  window_shift;
    logic [15:0] hold_seconds;
    logic [3:0]  max_errors;
    logic [4:0]  age_weight_shift;
  } cfg_t;

  typedef struct packed {
    logic    timed_out;
    logic    found;
    logic [5:0] slot;
    action_t action;
  } res_t;

endpackage

[hdl/hfbt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfbt_front
// Accepts input transfers, classifies the kind and queues up to two items.
// ----------------------------------------------------------------------------
module hfbt_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_kind,
  input  logic [31:0]    in_host_address,
  input  logic [31:0]    in_now,
  output logic           q_avail,
  output hfbt_pkg::item_t q_item,
  input  logic           q_pop
);
  import hfbt_pkg::*;

  item_t      slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic       push;
  op_t        op;

  always_comb begin
    case (in_kind)
      KIND_QUERY:   op = OP_QUERY;
      KIND_SUCCESS: op = OP_SUCCESS;
      KIND_FAILURE: op = OP_FAILURE;
      default:      op = OP_NONE;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_avail  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= '{op: op, addr: in_host_address, now: in_now};
    end
  end

endmodule

[hdl/hfbt_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfbt_engine
// Scans the table if needed, updates at most one entry and forms the result.
// ----------------------------------------------------------------------------
module hfbt_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  hfbt_pkg::cfg_t  cfg,
  input  logic            q_avail,
  input  hfbt_pkg::item_t q_item,
  output logic            q_pop,
  output logic            res_valid,
  input  logic            res_stall,
  output hfbt_pkg::res_t  res
);
  import hfbt_pkg::*;

  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] vld_r;
  entry_t             mem_q_r;
  logic               vq_r;

  eng_state_t state_r, state_nxt;
  item_t      item_r;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic       cmp_v_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic       issue;

  logic             hit_r, free_v_r, best_v_r;
  logic [IDX_W-1:0] hit_idx_r, free_idx_r, best_idx_r;
  logic [3:0]       hit_cnt_r;
  logic [31:0]      hit_time_r;
  logic [KEY_W-1:0] best_key_r;
  logic             lqf_r, lqf_nxt;
  res_t             res_r, res_nxt;

  entry_t           e;
  logic [KEY_W-1:0] key;
  logic             last_cmp;
  logic [31:0]      diff;
  logic [31:0]      window;
  logic [4:0]       inc;
  logic [3:0]       sat;
  logic             we;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] vict;
  entry_t           wr_data;

  assign e        = vq_r ? mem_q_r : '0;
  assign key      = KEY_W'(e.tstamp) + (KEY_W'(e.cnt) << cfg.age_weight_shift);
  assign issue    = (state_r == ES_SCAN) && (rd_idx_r < CNT_W'(ENTRIES));
  assign last_cmp = cmp_v_r && (cmp_idx_r == IDX_W'(ENTRIES - 1));
  assign diff     = item_r.now - hit_time_r;
  assign window   = 32'({1'b0, cfg.base_seconds} + {4'b0, cfg.jitter}) << cfg.window_shift;
  assign inc      = {1'b0, hit_cnt_r} + 5'd1;
  assign sat      = (inc > {1'b0, cfg.max_errors}) ? cfg.max_errors : inc[3:0];
  assign vict     = free_v_r ? free_idx_r : best_idx_r;

  assign res_valid = (state_r == ES_OUT);
  assign res       = res_r;

  // Next state, queue pop and the decision of one item.
  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    q_pop      = 1'b0;
    lqf_nxt    = lqf_r;
    res_nxt    = res_r;
    we         = 1'b0;
    wr_idx     = hit_idx_r;
    wr_data    = '{addr: item_r.addr, cnt: 4'd0, tstamp: hit_time_r};
    case (state_r)
      ES_IDLE: begin
        rd_idx_nxt = '0;
        if (q_avail) begin
          q_pop = 1'b1;
          if (q_item.op == OP_NONE ||
              (q_item.op == OP_SUCCESS && !lqf_r)) begin
            res_nxt   = '{timed_out: 1'b0, found: 1'b0, slot: 6'd0, action: ACT_NONE};
            state_nxt = ES_OUT;
          end else begin
            state_nxt = ES_SCAN;
          end
        end
      end
      ES_SCAN: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (last_cmp) begin
          state_nxt = ES_DECIDE;
        end
      end
      ES_DECIDE: begin
        res_nxt   = '{timed_out: 1'b0, found: hit_r,
                      slot: hit_r ? 6'(hit_idx_r) : 6'd0, action: ACT_NONE};
        state_nxt = ES_OUT;
        case (item_r.op)
          OP_QUERY: begin
            lqf_nxt = hit_r;
            res_nxt.timed_out = hit_r && (hit_cnt_r >= 4'd2) && (diff < window);
          end
          OP_SUCCESS: begin
            if (hit_r) begin
              we             = 1'b1;
              res_nxt.action = ACT_CLEARED;
            end
          end
          OP_FAILURE: begin
            if (hit_r) begin
              if (hit_cnt_r != 4'd0 && diff < {16'd0, cfg.hold_seconds}) begin
                res_nxt.action = ACT_HELD;
              end else begin
                we             = 1'b1;
                wr_data        = '{addr: item_r.addr, cnt: sat, tstamp: item_r.now};
                res_nxt.action = ACT_COUNTED;
              end
            end else begin
              we             = 1'b1;
              wr_idx         = vict;
              wr_data        = '{addr: item_r.addr, cnt: 4'd1, tstamp: item_r.now};
              res_nxt.slot   = 6'(vict);
              res_nxt.action = ACT_INSERTED;
            end
          end
          default: ;
        endcase
      end
      ES_OUT: begin
        if (!res_stall) begin
          state_nxt = ES_IDLE;
        end
      end
      default: state_nxt = ES_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ES_IDLE;
      rd_idx_r <= '0;
      cmp_v_r  <= 1'b0;
      lqf_r    <= 1'b0;
      vld_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
      cmp_v_r  <= issue;
      lqf_r    <= lqf_nxt;
      if (we) begin
        vld_r[wr_idx] <= 1'b1;
      end
    end
  end

  // Table memory: one read and one write port, read data registered.
  always_ff @(posedge clk) begin
    mem_q_r <= mem[rd_idx_r[IDX_W-1:0]];
    vq_r    <= vld_r[rd_idx_r[IDX_W-1:0]];
    if (we) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Scan tracking: first match, first free entry, oldest-weighted entry.
  always_ff @(posedge clk) begin
    cmp_idx_r <= rd_idx_r[IDX_W-1:0];
    res_r     <= res_nxt;
    if (state_r == ES_IDLE) begin
      item_r   <= q_item;
      hit_r    <= 1'b0;
      free_v_r <= 1'b0;
      best_v_r <= 1'b0;
    end else if (cmp_v_r) begin
      if (!hit_r && e.addr == item_r.addr) begin
        hit_r      <= 1'b1;
        hit_idx_r  <= cmp_idx_r;
        hit_cnt_r  <= e.cnt;
        hit_time_r <= e.tstamp;
      end
      if (!free_v_r && e.cnt == 4'd0) begin
        free_v_r   <= 1'b1;
        free_idx_r <= cmp_idx_r;
      end
      if (!best_v_r || key < best_key_r) begin
        best_v_r   <= 1'b1;
        best_key_r <= key;
        best_idx_r <= cmp_idx_r;
      end
    end
  end

endmodule

[hdl/host_failure_backoff_table.sv]
`timescale 1ns / 1ps
// Path: front queue, scan of all ENTRIES entries, decide, output; unknown kinds and
//   success reports while the last query found no entry (or none came yet) skip the scan.
// Items go through the engine one at a time, each scan reading the table through the
//   one read port of the table memory; the front holds up to two items meanwhile.
// Reset (rst_n, synchronous): table reads as all zero through per-entry valid bits,
//   registers return to their defaults, no clearing pass is needed.
// ----------------------------------------------------------------------------
// host_failure_backoff_table
// Table of remote hosts with failure counts; answers backoff queries.
// ----------------------------------------------------------------------------
module host_failure_backoff_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_host_address,
  input  logic [31:0] in_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_timed_out,
  output logic        out_found,
  output logic [5:0]  out_slot,
  output logic [2:0]  out_action,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hfbt_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  cfg_we;
  logic  q_avail, q_pop;
  item_t q_item;
  res_t  res;

  // Configuration registers: write on the access phase of an APB transfer.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_BASE: cfg_nxt.base_seconds     = pwdata[7:0];
        REG_JIT:  cfg_nxt.jitter           = pwdata[4:0];
        REG_WSH:  cfg_nxt.window_shift     = pwdata[3:0];
        REG_HOLD: cfg_nxt.hold_seconds     = pwdata[15:0];
        REG_MAXE: cfg_nxt.max_errors       = pwdata[3:0];
        REG_AGE:  cfg_nxt.age_weight_shift = pwdata[4:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{base_seconds: BASE_RST, jitter: JIT_RST, window_shift: WSH_RST,
                 hold_seconds: HOLD_RST, max_errors: MAXE_RST, age_weight_shift: AGE_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back the addressed register, zero beyond the list.
  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_BASE: prdata = {24'd0, cfg_r.base_seconds};
      REG_JIT:  prdata = {27'd0, cfg_r.jitter};
      REG_WSH:  prdata = {28'd0, cfg_r.window_shift};
      REG_HOLD: prdata = {16'd0, cfg_r.hold_seconds};
      REG_MAXE: prdata = {28'd0, cfg_r.max_errors};
      REG_AGE:  prdata = {27'd0, cfg_r.age_weight_shift};
      default:  prdata = 32'd0;
    endcase
  end

  // Front: take transfers and hold up to two classified items.
  hfbt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_host_address (in_host_address),
    .in_now          (in_now),
    .q_avail         (q_avail),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  // Back: scan the table if needed, update at most one entry, hold the result until taken.
  hfbt_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_avail   (q_avail),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (out_valid),
    .res_stall (out_stall),
    .res       (res)
  );

  assign out_timed_out = res.timed_out;
  assign out_found     = res.found;
  assign out_slot      = res.slot;
  assign out_action    = res.action;

`ifndef SYNTHESIS
  a_tmo_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_timed_out) |-> (out_found && out_action == ACT_NONE))
    else $error("timed_out without a matched entry");

  a_insert_no_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == ACT_INSERTED) |-> !out_found)
    else $error("insert reported a match");

  a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found && out_action != ACT_INSERTED) |-> (out_slot == 6'd0))
    else $error("slot nonzero without match or insert");

  a_clear_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_action == ACT_CLEARED || out_action == ACT_COUNTED ||
                   out_action == ACT_HELD)) |-> out_found)
    else $error("entry update reported without a match");
`endif

endmodule
